>>> rtl/tbrr_pkg.sv
`default_nettype none

package tbrr_pkg;

   // Fixed field widths and connection count
   localparam int CONN_W = 4;
   localparam int NUM_CONN = 16;
   localparam int LEN_W = 24;
   localparam int TAG_W = 16;
   localparam int STAT_W = 2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_QUEUED = 2'd0;
   localparam logic [STAT_W-1:0] ST_DIRECT = 2'd1;
   localparam logic [STAT_W-1:0] ST_PASS = 2'd2;
   localparam logic [STAT_W-1:0] ST_DROP = 2'd3;

   // Request command codes
   localparam logic CMD_MSG = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Register indexes
   localparam logic REG_BUCKET = 1'b0;
   localparam logic REG_INCR = 1'b1;

   // One stored message
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
   } msg_type;

endpackage

`default_nettype wire

>>> rtl/token_bucket_round_robin_shaper_core.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/ready    cmd, is_piece, conn_id, byte_length, msg_tag
// rsp_      out        rsp_valid/ready    status, out_tag, out_conn, out_length, last
// csr_      in         APB psel/penable   bucket_size @0x0, token_increment @0x4
//
// A message request passes ARR, then returns to idle (bypass, direct send, drop) or
// goes on to ENQ (enqueue, after the free-slot stack read). A tick enters RD and runs
// RD then CHK per message sent from a queue, around the store memory read-modify-write;
// it leaves RD when queues run empty or the burst limit is hit, CHK when a head does
// not fit. Reset sets all control state at once; the never-used slots come from a fill
// count. A stalled response holds the sequencer; the next request waits in idle only.

module token_bucket_round_robin_shaper_core #(
   parameter int STORE_DEPTH = 256,
   parameter int MAX_BURST = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic        req_is_piece,
   input  wire logic [3:0]  req_conn_id,
   input  wire logic [23:0] req_byte_length,
   input  wire logic [15:0] req_msg_tag,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_tag,
   output logic [3:0]       rsp_out_conn,
   output logic [23:0]      rsp_out_length,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int SW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int BW = $clog2(MAX_BURST + 1);
   localparam int NC = tbrr_pkg::NUM_CONN;
   localparam int LW = tbrr_pkg::LEN_W;
   localparam int KW = tbrr_pkg::CONN_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ARR = 3'd1;
   localparam logic [2:0] S_ENQ = 3'd2;
   localparam logic [2:0] S_RD = 3'd3;
   localparam logic [2:0] S_CHK = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [LW-1:0] tc_ff, tc_in;
   logic [LW-1:0] bsz_ff, bsz_in;
   logic [LW-1:0] inc_ff, inc_in;
   logic a_piece_ff, a_piece_in;
   logic [KW-1:0] a_conn_ff, a_conn_in;
   tbrr_pkg::msg_type a_msg_ff, a_msg_in;
   logic [KW-1:0] sp_ff, sp_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] qcnt_ff [NC];
   logic [CW-1:0] qcnt_in [NC];
   logic [SW-1:0] head_ff [NC];
   logic [SW-1:0] head_in [NC];
   logic [SW-1:0] tail_ff [NC];
   logic [SW-1:0] tail_in [NC];
   logic [NC-1:0] ne_ff, ne_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] top_ff, top_in;
   logic [BW-1:0] burst_ff, burst_in;
   logic [SW-1:0] h_ff, h_in;
   logic pend_ff, pend_in;
   logic [KW-1:0] pend_conn_ff, pend_conn_in;
   tbrr_pkg::msg_type pend_msg_ff, pend_msg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [KW-1:0] rsp_conn_ff, rsp_conn_in;
   tbrr_pkg::msg_type rsp_msg_ff, rsp_msg_in;
   logic rsp_last_ff, rsp_last_in;

   logic [SW-1:0] stk_mem [STORE_DEPTH];
   logic [SW-1:0] stk_rd_ff;
   logic stk_rd_en;
   logic stk_we;

   logic st_wr_en;
   logic [SW-1:0] st_wr_addr;
   logic lk_en;
   logic [SW-1:0] lk_addr;
   logic st_rd_en;
   tbrr_pkg::msg_type rd_msg;
   logic [SW-1:0] rd_link;

   logic out_free;
   logic [LW:0] tick_sum;
   logic fits;
   logic [SW-1:0] slot;
   logic [NC-1:0] ne_after;
   logic [KW-1:0] nxt_sp;
   logic [KW-1:0] probe;
   logic csr_wr;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tick_sum = {1'b0, tc_ff} + {1'b0, inc_ff};
   assign fits = rd_msg.len <= tc_ff;
   assign slot = (fill_ff < CW'(STORE_DEPTH)) ? fill_ff[SW-1:0] : stk_rd_ff;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Find the next non-empty queue after the served one
   always_comb begin
      ne_after = ne_ff;
      if (qcnt_ff[sp_ff] == CW'(1)) begin
         ne_after[sp_ff] = 1'b0;
      end
      nxt_sp = sp_ff;
      probe = '0;
      for (int i = NC - 1; i >= 0; i--) begin
         probe = sp_ff + KW'(1) + KW'(i);
         if (ne_after[probe]) begin
            nxt_sp = probe;
         end
      end
   end

   // Sequence requests and queue service
   always_comb begin
      state_in = state_ff;
      tc_in = tc_ff;
      bsz_in = bsz_ff;
      inc_in = inc_ff;
      a_piece_in = a_piece_ff;
      a_conn_in = a_conn_ff;
      a_msg_in = a_msg_ff;
      sp_in = sp_ff;
      total_in = total_ff;
      qcnt_in = qcnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      ne_in = ne_ff;
      fill_in = fill_ff;
      top_in = top_ff;
      burst_in = burst_ff;
      h_in = h_ff;
      pend_in = pend_ff;
      pend_conn_in = pend_conn_ff;
      pend_msg_in = pend_msg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_conn_in = rsp_conn_ff;
      rsp_msg_in = rsp_msg_ff;
      rsp_last_in = rsp_last_ff;
      stk_rd_en = 1'b0;
      stk_we = 1'b0;
      st_wr_en = 1'b0;
      st_wr_addr = slot;
      lk_en = 1'b0;
      lk_addr = tail_ff[a_conn_ff];
      st_rd_en = 1'b0;

      // Take register writes
      if (csr_wr) begin
         if (csr_paddr[2] == tbrr_pkg::REG_BUCKET) begin
            bsz_in = csr_pwdata[LW-1:0];
         end else begin
            inc_in = csr_pwdata[LW-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == tbrr_pkg::CMD_TICK) begin
                  tc_in = (tick_sum > {1'b0, bsz_ff}) ? bsz_ff : tick_sum[LW-1:0];
                  burst_in = '0;
                  state_in = S_RD;
               end else begin
                  a_piece_in = req_is_piece;
                  a_conn_in = req_conn_id;
                  a_msg_in.tag = req_msg_tag;
                  a_msg_in.len = req_byte_length;
                  state_in = S_ARR;
               end
            end
         end
         S_ARR: begin
            if (!a_piece_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = tbrr_pkg::ST_PASS;
                  rsp_conn_in = a_conn_ff;
                  rsp_msg_in = a_msg_ff;
                  rsp_last_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (total_ff == '0 && a_msg_ff.len <= tc_ff) begin
               if (out_free) begin
                  tc_in = tc_ff - a_msg_ff.len;
                  rsp_valid_in = 1'b1;
                  rsp_status_in = tbrr_pkg::ST_DIRECT;
                  rsp_conn_in = a_conn_ff;
                  rsp_msg_in = a_msg_ff;
                  rsp_last_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (total_ff >= CW'(STORE_DEPTH)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = tbrr_pkg::ST_DROP;
                  rsp_conn_in = a_conn_ff;
                  rsp_msg_in = a_msg_ff;
                  rsp_last_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               // fetch top of free-slot stack
               stk_rd_en = 1'b1;
               state_in = S_ENQ;
            end
         end
         S_ENQ: begin
            if (fill_ff < CW'(STORE_DEPTH)) begin
               fill_in = fill_ff + CW'(1);
            end else begin
               top_in = top_ff - CW'(1);
            end
            st_wr_en = 1'b1;
            if (qcnt_ff[a_conn_ff] != '0) begin
               lk_en = 1'b1;
            end else begin
               head_in[a_conn_ff] = slot;
            end
            tail_in[a_conn_ff] = slot;
            qcnt_in[a_conn_ff] = qcnt_ff[a_conn_ff] + CW'(1);
            ne_in[a_conn_ff] = 1'b1;
            if (total_ff == '0) begin
               sp_in = a_conn_ff;
            end
            total_in = total_ff + CW'(1);
            state_in = S_IDLE;
         end
         S_RD: begin
            if (total_ff != '0 && burst_ff < BW'(MAX_BURST)) begin
               st_rd_en = 1'b1;
               h_in = head_ff[sp_ff];
               state_in = S_CHK;
            end else if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = tbrr_pkg::ST_QUEUED;
               rsp_conn_in = pend_conn_ff;
               rsp_msg_in = pend_msg_ff;
               rsp_last_in = 1'b1;
               pend_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_CHK: begin
            if (!pend_ff || out_free) begin
               // flush held send; last when this head does not fit
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = tbrr_pkg::ST_QUEUED;
                  rsp_conn_in = pend_conn_ff;
                  rsp_msg_in = pend_msg_ff;
                  rsp_last_in = !fits;
               end
               pend_in = 1'b0;
               if (fits) begin
                  pend_in = 1'b1;
                  pend_conn_in = sp_ff;
                  pend_msg_in = rd_msg;
                  tc_in = tc_ff - rd_msg.len;
                  head_in[sp_ff] = rd_link;
                  stk_we = 1'b1;
                  top_in = top_ff + CW'(1);
                  qcnt_in[sp_ff] = qcnt_ff[sp_ff] - CW'(1);
                  ne_in = ne_after;
                  total_in = total_ff - CW'(1);
                  sp_in = nxt_sp;
                  burst_in = burst_ff + BW'(1);
                  state_in = S_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Update control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tc_ff <= '0;
         bsz_ff <= LW'(65536);
         inc_ff <= LW'(1024);
         sp_ff <= '0;
         total_ff <= '0;
         ne_ff <= '0;
         fill_ff <= '0;
         top_ff <= '0;
         burst_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NC; i++) begin
            qcnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         tc_ff <= tc_in;
         bsz_ff <= bsz_in;
         inc_ff <= inc_in;
         sp_ff <= sp_in;
         total_ff <= total_in;
         ne_ff <= ne_in;
         fill_ff <= fill_in;
         top_ff <= top_in;
         burst_ff <= burst_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         qcnt_ff <= qcnt_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      a_piece_ff <= a_piece_in;
      a_conn_ff <= a_conn_in;
      a_msg_ff <= a_msg_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      h_ff <= h_in;
      pend_conn_ff <= pend_conn_in;
      pend_msg_ff <= pend_msg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_conn_ff <= rsp_conn_in;
      rsp_msg_ff <= rsp_msg_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Free-slot stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[top_ff[SW-1:0]] <= h_ff;
      end
      if (stk_rd_en) begin
         stk_rd_ff <= stk_mem[top_ff[SW-1:0] - SW'(1)];
      end
   end

   tbrr_store #(
      .DEPTH(STORE_DEPTH),
      .AW(SW)
   ) u_store (
      .clock(clock),
      .wr_en(st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_msg(a_msg_ff),
      .lk_en(lk_en),
      .lk_addr(lk_addr),
      .lk_data(slot),
      .rd_en(st_rd_en),
      .rd_addr(head_ff[sp_ff]),
      .rd_msg(rd_msg),
      .rd_link(rd_link)
   );

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_tag = rsp_msg_ff.tag;
   assign rsp_out_conn = rsp_conn_ff;
   assign rsp_out_length = rsp_msg_ff.len;
   assign rsp_last = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tbrr_pkg::REG_INCR) ? {8'd0, inc_ff} : {8'd0, bsz_ff};

   // Free slots plus queued messages account for every slot handed out
   a_slots: assert property (@(posedge clock) disable iff (reset)
      top_ff + total_ff == fill_ff)
      else $error("slot accounting broken");

   // Non-empty map agrees with the total count
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) == (ne_ff == '0))
      else $error("non-empty map out of step with total");

   // Service pointer names a non-empty queue while messages wait
   a_pointer: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) |-> ne_ff[sp_ff])
      else $error("service pointer on empty queue");

   // Burst never exceeds its limit
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> (burst_ff < BW'(MAX_BURST)))
      else $error("burst limit exceeded");

endmodule

`default_nettype wire

>>> rtl/tbrr_store.sv
`default_nettype none

module tbrr_store #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire tbrr_pkg::msg_type wr_msg,
   input  wire logic            lk_en,
   input  wire logic [AW-1:0]   lk_addr,
   input  wire logic [AW-1:0]   lk_data,
   input  wire logic            rd_en,
   input  wire logic [AW-1:0]   rd_addr,
   output tbrr_pkg::msg_type    rd_msg,
   output logic [AW-1:0]        rd_link
);

   tbrr_pkg::msg_type msg_mem [DEPTH];
   logic [AW-1:0] link_mem [DEPTH];
   tbrr_pkg::msg_type rd_msg_ff;
   logic [AW-1:0] rd_link_ff;

   // Write and read message payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         msg_mem[wr_addr] <= wr_msg;
      end
      if (rd_en) begin
         rd_msg_ff <= msg_mem[rd_addr];
      end
   end

   // Write and read next-slot links
   always_ff @(posedge clock) begin
      if (lk_en) begin
         link_mem[lk_addr] <= lk_data;
      end
      if (rd_en) begin
         rd_link_ff <= link_mem[rd_addr];
      end
   end

   assign rd_msg = rd_msg_ff;
   assign rd_link = rd_link_ff;

endmodule

`default_nettype wire
